@@ sv/pdbc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdbc_pkg
// Types and constants shared by the packet deframer with BSD checksum.
// ----------------------------------------------------------------------------
package pdbc_pkg;

	// Longest accepted length field (message ID plus payload)
	localparam logic [7:0] MAX_LEN = 8'd128;

	// Register reset values
	localparam logic [7:0] START_BYTE_RST = 8'hCC;
	localparam logic [7:0] END_BYTE_RST   = 8'hB9;

	// Register indexes
	localparam logic CFG_START_BYTE = 1'b0;
	localparam logic CFG_END_BYTE   = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN  = 3'd1,
		PH_BODY = 3'd2,
		PH_TAIL = 3'd3,
		PH_CSUM = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		ST_NONE   = 3'd0,
		ST_GOOD   = 3'd1,
		ST_BADSUM = 3'd2,
		ST_NOEND  = 3'd3,
		ST_BADLEN = 3'd4
	} status_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] exp_len;
		logic [7:0] seen;
		logic [7:0] sum;
	} frame_state_t;

	typedef struct packed {
		status_t    status;
		logic       byte_valid;
		logic [7:0] byte_value;
		logic [6:0] byte_index;
		logic [7:0] packet_length;
		logic [7:0] computed_checksum;
	} frame_result_t;

	// BSD checksum step: rotate right by one, then add the byte
	function automatic logic [7:0] bsd_fold(input logic [7:0] sum, input logic [7:0] b);
		logic [7:0] rot;
		rot = {sum[0], sum[7:1]};
		return rot + b;
	endfunction

endpackage

@@ sv/pdbc_step.sv @@
// ----------------------------------------------------------------------------
// pdbc_step
// Per-byte deframer update: next frame state and the result for one item.
// ----------------------------------------------------------------------------
module pdbc_step import pdbc_pkg::*; (
	input  frame_state_t  st,
	input  logic [7:0]    rx,
	input  logic [7:0]    start_byte,
	input  logic [7:0]    end_byte,
	output frame_state_t  st_nxt,
	output frame_result_t res
);

	logic [7:0] seen_inc;

	assign seen_inc = st.seen + 8'd1;

	// Next state
	always_comb begin
		st_nxt = st;
		unique case (st.phase)
			PH_LEN: begin
				st_nxt.exp_len = rx;
				if (rx == 8'd0 || rx > MAX_LEN) begin
					st_nxt.phase = PH_HUNT;
				end else begin
					st_nxt.phase = PH_BODY;
				end
			end
			PH_BODY: begin
				st_nxt.sum  = bsd_fold(st.sum, rx);
				st_nxt.seen = seen_inc;
				if (seen_inc >= st.exp_len) begin
					st_nxt.phase = PH_TAIL;
				end
			end
			PH_TAIL: begin
				st_nxt.phase = (rx == end_byte) ? PH_CSUM : PH_HUNT;
			end
			PH_CSUM: begin
				st_nxt.phase = PH_HUNT;
			end
			default: begin
				st_nxt.phase = PH_HUNT;
				if (rx == start_byte) begin
					st_nxt.exp_len = 8'd0;
					st_nxt.seen    = 8'd0;
					st_nxt.sum     = 8'd0;
					st_nxt.phase   = PH_LEN;
				end
			end
		endcase
	end

	// Result for this item
	always_comb begin
		res.status            = ST_NONE;
		res.byte_valid        = 1'b0;
		res.byte_value        = 8'd0;
		res.byte_index        = 7'd0;
		res.packet_length     = st_nxt.exp_len;
		res.computed_checksum = st_nxt.sum;
		unique case (st.phase)
			PH_LEN: begin
				if (rx == 8'd0 || rx > MAX_LEN) begin
					res.status = ST_BADLEN;
				end
			end
			PH_BODY: begin
				res.byte_valid = 1'b1;
				res.byte_value = rx;
				res.byte_index = st.seen[6:0];
			end
			PH_TAIL: begin
				if (rx != end_byte) begin
					res.status = ST_NOEND;
				end
			end
			PH_CSUM: begin
				res.status = (rx == st.sum) ? ST_GOOD : ST_BADSUM;
			end
			default: begin
				res.status = ST_NONE;
			end
		endcase
	end

endmodule

@@ sv/packet_deframer_bsd_checksum_core.sv @@
// ----------------------------------------------------------------------------
// packet_deframer_bsd_checksum_core
// Serial packet deframer with 8-bit BSD rotate-and-add checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per item and returns exactly one result per item.
// Frame: start byte, length byte (ID plus payload, 1..128), that many bytes,
// end byte, checksum byte. ID and payload bytes come out with their index;
// status reports good packet, bad checksum, missing end byte or bad length.
// Throughput is one item per clock while the output is not stalled. An item
// passes through one input register, the per-byte state update, and one
// result register. The input side stalls only while its register holds an
// item and the result register is full and stalled.
module packet_deframer_bsd_checksum_core import pdbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_wdata,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] status,
	output logic       byte_valid,
	output logic [7:0] byte_value,
	output logic [6:0] byte_index,
	output logic [7:0] packet_length,
	output logic [7:0] computed_checksum
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          adv_s1;
	logic [7:0]    start_byte_q;
	logic [7:0]    end_byte_q;
	frame_state_t  st_q;
	frame_state_t  st_nxt;
	frame_result_t res_nxt;
	frame_result_t res_q;
	logic          out_valid_q;

	// Advance stage 1 when the result register is empty or being taken
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE: start_byte_q <= cfg_wdata;
				CFG_END_BYTE:   end_byte_q   <= cfg_wdata;
				default:        start_byte_q <= start_byte_q;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	pdbc_step u_step (
		.st         (st_q),
		.rx         (byte_s1),
		.start_byte (start_byte_q),
		.end_byte   (end_byte_q),
		.st_nxt     (st_nxt),
		.res        (res_nxt)
	);

	// Frame state: update once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase   <= PH_HUNT;
			st_q.exp_len <= 8'd0;
			st_q.seen    <= 8'd0;
			st_q.sum     <= 8'd0;
		end else if (adv_s1) begin
			st_q <= st_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = res_q.status;
	assign byte_valid        = res_q.byte_valid;
	assign byte_value        = res_q.byte_value;
	assign byte_index        = res_q.byte_index;
	assign packet_length     = res_q.packet_length;
	assign computed_checksum = res_q.computed_checksum;

	// Body phase always has bytes left to take
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_BODY |-> st_q.seen < st_q.exp_len)
		else $error("body phase with no bytes left");

	// Body phase only with a legal length
	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_BODY |-> (st_q.exp_len != 8'd0 && st_q.exp_len <= MAX_LEN))
		else $error("body phase with illegal length");

	// A data byte never carries a status
	a_data_no_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.byte_valid |-> res_q.status == ST_NONE)
		else $error("data byte with status");

	// A blocked item holds in stage 1
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1))
		else $error("stage 1 item lost while blocked");

endmodule
